FILE: sv/mmcs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the min/max contrast stretcher.
// Used by the front, queue, back and top level modules.
package mmcs_pkg;

	localparam int PIX_W       = 8;
	localparam int NUM_W       = 2 * PIX_W;
	localparam int CNT_W       = $clog2(NUM_W);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PIX_W-1:0] PIX_MAX   = {PIX_W{1'b1}};
	localparam logic [PIX_W-1:0] PIX_MIN   = '0;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

	// Input kind selector
	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_STRETCH = 1'b1;

	// One stretch job: numerator (diff * 255), divisor (max - min), flat flag
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [PIX_W-1:0] den;
		logic             flat;
	} job_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

FILE: sv/min_max_contrast_stretch.sv
`timescale 1ns / 1ps
// Measure beats (tuser kind 0) update the running min/max; a frame_start
// beat restarts both from its pixel. Stretch beats (kind 1) are queued and
// divided by a bit-serial divider, one quotient bit per cycle: each job is
// loaded, run through 16 divide steps and output, and a flat frame is
// loaded and output with no divide steps. The job queue lets measure beats
// and up to QUEUE_DEPTH stretch beats be taken while the divider is busy.
module min_max_contrast_stretch #(
	parameter int QUEUE_DEPTH = mmcs_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [mmcs_pkg::PIX_W-1:0] s_tdata,  // [7:0] pixel
	input  logic [1:0]                s_tuser,  // [0] kind, [1] frame_start
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [mmcs_pkg::PIX_W-1:0] m_tdata,  // [7:0] stretched
	output logic [0:0]                m_tuser   // [0] flat
);
	import mmcs_pkg::*;

	logic accept;
	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t push_job;
	job_t pop_job;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	mmcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (s_tuser[0]),
		.pixel       (s_tdata),
		.frame_start (s_tuser[1]),
		.push        (push),
		.job         (push_job)
	);

	mmcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_job),
		.empty     (empty)
	);

	mmcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (!empty),
		.job       (pop_job),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

FILE: sv/mmcs_front.sv
`timescale 1ns / 1ps
// Front end: tracks the running min/max on measure beats and turns
// stretch beats into divide jobs. Depends on mmcs_pkg.
module mmcs_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      kind,
	input  logic [mmcs_pkg::PIX_W-1:0] pixel,
	input  logic                      frame_start,
	output logic                      push,
	output mmcs_pkg::job_t            job
);
	import mmcs_pkg::*;

	logic [PIX_W-1:0] low_q;
	logic [PIX_W-1:0] high_q;
	logic [PIX_W-1:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= PIX_MAX;
			high_q <= PIX_MIN;
		end else if (accept && kind == KIND_MEASURE) begin
			if (frame_start) begin
				low_q  <= pixel;
				high_q <= pixel;
			end else begin
				if (pixel > high_q) high_q <= pixel;
				if (pixel < low_q)  low_q  <= pixel;
			end
		end
	end

	// Difference wraps modulo 256 for pixels below the minimum
	assign diff = pixel - low_q;

	always_comb begin
		push     = accept && kind == KIND_STRETCH;
		job.num  = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
		job.den  = high_q - low_q;
		job.flat = high_q <= low_q;
	end

endmodule

FILE: sv/mmcs_queue.sv
`timescale 1ns / 1ps
// Small job queue between front and back ends.
// Depends on mmcs_pkg for the job type.
module mmcs_queue #(
	parameter int DEPTH = mmcs_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mmcs_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output mmcs_pkg::job_t pop_data,
	output logic           empty
);
	import mmcs_pkg::*;

	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(DEPTH - 1);
	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

	job_t               mem [DEPTH];
	logic [IDX_W-1:0]   wr_ptr_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;

	assign full     = count_q == FULL_COUNT;
	assign empty    = count_q == '0;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/mmcs_back.sv
`timescale 1ns / 1ps
// Back end: bit-serial restoring divider for diff*255/range with
// saturation, plus the output register. Depends on mmcs_pkg.
module mmcs_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_avail,
	input  mmcs_pkg::job_t            job,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [mmcs_pkg::PIX_W-1:0] m_tdata,
	output logic [0:0]                m_tuser
);
	import mmcs_pkg::*;

	back_state_t      state_q, state_d;
	logic [NUM_W-1:0] num_q;
	logic [PIX_W-1:0] rem_q;
	logic [PIX_W-1:0] den_q;
	logic             flat_q;
	logic [CNT_W-1:0] cnt_q;

	logic [PIX_W:0]   rem_sh;
	logic             ge;
	logic [PIX_W:0]   rem_sub;
	logic             out_free;
	logic             load_out;
	logic [PIX_W-1:0] quo_sat;

	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign ge       = rem_sh >= {1'b0, den_q};
	assign rem_sub  = rem_sh - {1'b0, den_q};
	assign out_free = !m_tvalid || m_tready;
	assign quo_sat  = (|num_q[NUM_W-1:PIX_W]) ? PIX_MAX : num_q[PIX_W-1:0];

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (job_avail) begin
					pop     = 1'b1;
					state_d = job.flat ? B_DONE : B_DIV;
				end
			end
			B_DIV: begin
				if (cnt_q == LAST_STEP) state_d = B_DONE;
			end
			B_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop)                  cnt_q <= '0;
			else if (state_q == B_DIV) cnt_q <= cnt_q + 1'b1;
			if (load_out)      m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	// Datapath: load job, then shift one quotient bit in per cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			num_q  <= job.flat ? '0 : job.num;
			den_q  <= job.den;
			flat_q <= job.flat;
			rem_q  <= '0;
		end else if (state_q == B_DIV) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[PIX_W-1:0] : rem_sh[PIX_W-1:0];
		end
		if (load_out) begin
			m_tdata    <= quo_sat;
			m_tuser[0] <= flat_q;
		end
	end

endmodule

FILE: verif/min_max_contrast_stretch_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_max_contrast_stretch: directed table, then random frames.
// Depends on mmcs_pkg for the pixel width and the kind selector codes.
module min_max_contrast_stretch_tb;
	import mmcs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_ITEMS = 900;

	typedef struct packed {
		logic [PIX_W-1:0] level;
		logic             flat;
	} stretch_res_t;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pix;
		logic             fs;
		logic             pinned;
		logic [PIX_W-1:0] level;
		logic             flat;
	} plan_row_t;

	typedef struct packed {
		logic         pinned;
		stretch_res_t res;
	} beat_note_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [PIX_W-1:0] s_tdata = '0;
	logic [1:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [PIX_W-1:0] m_tdata;
	logic [0:0]       m_tuser;

	logic [PIX_W-1:0] frame_min;
	logic [PIX_W-1:0] frame_max;
	stretch_res_t     expected_pix[$];
	beat_note_t       beat_notes[$];
	int               errors = 0;
	int               sent = 0;
	int               cycles = 0;
	int               rx_cycles = 0;

	// Directed rows; level/flat are only meaningful where pinned is set
	plan_row_t plan[25] = '{
		'{KIND_STRETCH, 8'd0,   1'b0, 1'b1, 8'd0,   1'b1},  // nothing measured yet
		'{KIND_MEASURE, 8'd100, 1'b0, 1'b0, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd100, 1'b0, 1'b1, 8'd0,   1'b1},  // min equals max
		'{KIND_MEASURE, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
		'{KIND_MEASURE, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
		'{KIND_STRETCH, 8'd128, 1'b0, 1'b1, 8'd128, 1'b0},
		'{KIND_MEASURE, 8'd50,  1'b1, 1'b0, 8'd0,   1'b0},
		'{KIND_MEASURE, 8'd150, 1'b0, 1'b0, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd150, 1'b0, 1'b1, 8'd255, 1'b0},
		'{KIND_STRETCH, 8'd50,  1'b0, 1'b1, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd49,  1'b0, 1'b1, 8'd255, 1'b0},  // below min, wraps and saturates
		'{KIND_STRETCH, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd100, 1'b0, 1'b0, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd1,   1'b1, 1'b0, 8'd0,   1'b0},  // frame_start ignored on stretch
		'{KIND_MEASURE, 8'd254, 1'b1, 1'b0, 8'd0,   1'b0},
		'{KIND_MEASURE, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd254, 1'b0, 1'b1, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
		'{KIND_STRETCH, 8'd0,   1'b0, 1'b1, 8'd255, 1'b0},
		'{KIND_MEASURE, 8'd7,   1'b1, 1'b0, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd7,   1'b0, 1'b1, 8'd0,   1'b1},
		'{KIND_MEASURE, 8'd3,   1'b0, 1'b0, 8'd0,   1'b0},
		'{KIND_STRETCH, 8'd5,   1'b0, 1'b0, 8'd0,   1'b0}
	};

	min_max_contrast_stretch u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Track min/max and work out the stretched pixel for one accepted beat
	task automatic stretch_predict(input logic kind, input logic [PIX_W-1:0] pix,
			input logic fs, output bit has_res, output stretch_res_t res);
		int unsigned span;
		int unsigned diff;
		int unsigned scaled;
		has_res = 1'b0;
		res = '0;
		if (kind == KIND_MEASURE) begin
			if (fs) begin
				frame_min = pix;
				frame_max = pix;
			end else begin
				if (pix > frame_max) frame_max = pix;
				if (pix < frame_min) frame_min = pix;
			end
		end else begin
			has_res = 1'b1;
			if (frame_max <= frame_min) begin
				res.level = PIX_MIN;
				res.flat = 1'b1;
			end else begin
				span = 32'(frame_max) - 32'(frame_min);
				diff = (32'(pix) - 32'(frame_min)) & 32'hFF;
				scaled = (diff * 32'd255) / span;
				res.level = (scaled > 32'd255) ? PIX_MAX : scaled[PIX_W-1:0];
				res.flat = 1'b0;
			end
		end
	endtask

	task automatic send_beat(input logic kind, input logic [PIX_W-1:0] pix, input logic fs,
			input logic pinned, input stretch_res_t pinned_res);
		bit calm;
		calm = (sent >= 400 && sent < 550);
		beat_notes.push_back(beat_note_t'{pinned, pinned_res});
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tuser <= {fs, kind};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Scoreboard: check output beats first, then predict from input beats
	always @(posedge clk) begin
		bit           has_res;
		stretch_res_t res;
		stretch_res_t want;
		beat_note_t   note;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_pix.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat stretched=%0d flat=%0b",
						$realtime, m_tdata, m_tuser[0]);
				end else begin
					want = expected_pix.pop_front();
					if (m_tdata !== want.level) begin
						errors++;
						$display("%0t: stretched expected %0d actual %0d",
							$realtime, want.level, m_tdata);
					end
					if (m_tuser[0] !== want.flat) begin
						errors++;
						$display("%0t: flat expected %0b actual %0b",
							$realtime, want.flat, m_tuser[0]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				stretch_predict(s_tuser[0], s_tdata, s_tuser[1], has_res, res);
				note = beat_notes.pop_front();
				if (has_res)
					expected_pix.push_back(note.pinned ? note.res : res);
			end
		end
	end

	// Receiver: random stalls, one long hold-off, one calm stretch
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rx_cycles >= 1500 && rx_cycles < 1900) begin
				m_tready <= 1'b0;
			end else if (rx_cycles >= 6000 && rx_cycles < 9000) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 33);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int           lo;
		int           hi;
		int           n_meas;
		int           n_str;
		stretch_res_t none;
		none = '0;
		frame_min = PIX_MAX;
		frame_max = PIX_MIN;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_beat(plan[i].kind, plan[i].pix, plan[i].fs, plan[i].pinned,
				stretch_res_t'{plan[i].level, plan[i].flat});

		while (sent < $size(plan) + RANDOM_ITEMS) begin
			if ($urandom_range(9) == 0) begin
				// noise: arbitrary beats, including measures with no frame start
				repeat ($urandom_range(6, 1))
					send_beat(1'($urandom_range(1)), PIX_W'($urandom_range(255)),
						1'($urandom_range(1)), 1'b0, none);
			end else begin
				lo = $urandom_range(255);
				case ($urandom_range(3))
					0: hi = lo;
					1: hi = lo + $urandom_range(3, 1);
					2: hi = lo + $urandom_range(40);
					default: hi = lo + $urandom_range(255);
				endcase
				if (hi > 255) hi = 255;
				n_meas = $urandom_range(6, 1);
				n_str = $urandom_range(8, 1);
				send_beat(KIND_MEASURE, PIX_W'($urandom_range(hi, lo)), 1'b1, 1'b0, none);
				repeat (n_meas - 1)
					send_beat(KIND_MEASURE, PIX_W'($urandom_range(hi, lo)), 1'b0, 1'b0,
						none);
				repeat (n_str) begin
					if ($urandom_range(9) < 8)
						send_beat(KIND_STRETCH, PIX_W'($urandom_range(hi, lo)),
							1'($urandom_range(1)), 1'b0, none);
					else
						send_beat(KIND_STRETCH, PIX_W'($urandom_range(255)),
							1'($urandom_range(1)), 1'b0, none);
				end
			end
		end
		s_tvalid <= 1'b0;

		while (beat_notes.size() != 0 || expected_pix.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/mmcs_pkg.sv
sv/mmcs_front.sv
sv/mmcs_queue.sv
sv/mmcs_back.sv
sv/min_max_contrast_stretch.sv
verif/min_max_contrast_stretch_tb.sv
